// ===== design/fqs_pkg.sv =====
package fqs_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DEQ_EMPTY = 2'd1,
    ST_ENQ_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FRONT,
    S_EMIT
  } state_t;

  // result fields of fixed width; the count travels beside it
  typedef struct packed {
    status_t             status;
    logic                found;
    logic [DATA_W-1:0]   front;
    logic [DATA_W-1:0]   rear;
  } res_t;

endpackage

// ===== design/fqs_ram.sv =====
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fqs_ctrl.sv =====
module fqs_ctrl
  import fqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  action_t                    act,
  input  logic [DATA_W-1:0]          val,
  input  logic                       out_free,
  output logic                       busy,
  output logic                       res_load,
  output res_t                       res,
  output logic [$clog2(DEPTH+1)-1:0] res_count,
  output logic                       wr_en,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [DATA_W-1:0]          wr_data,
  output logic                       rd_en,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [DATA_W-1:0]          rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] front_r, front_nxt;
  logic [DATA_W-1:0] rear_r, rear_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic              found_r, found_nxt;
  status_t           status;
  logic              hit;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // read data of the previous cycle's issued read
  assign hit  = (rd_data == key_r);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (act)
            ACT_DEQ: begin
              if (count_r != '0 && count_r != CW'(1)) state_nxt = S_FRONT;
            end
            ACT_SEARCH: begin
              if (count_r != '0) state_nxt = S_SEARCH;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (hit || left_r == '0) state_nxt = S_EMIT;
      end
      S_FRONT: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    key_nxt   = key_r;
    scan_nxt  = scan_r;
    left_nxt  = left_r;
    found_nxt = found_r;
    status    = ST_OK;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    wr_data   = val;
    rd_en     = 1'b0;
    rd_addr   = scan_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          found_nxt = 1'b0;
          case (act)
            ACT_ENQ: begin
              if (count_r < CW'(DEPTH)) begin
                wr_en     = 1'b1;
                tail_nxt  = ring_next(tail_r);
                count_nxt = count_r + 1'b1;
                rear_nxt  = val;
                if (count_r == '0) front_nxt = val;
              end else begin
                status = ST_ENQ_FULL;
              end
            end
            ACT_DEQ: begin
              if (count_r == '0) begin
                status = ST_DEQ_EMPTY;
              end else begin
                // fetch the new front entry
                head_nxt  = ring_next(head_r);
                count_nxt = count_r - 1'b1;
                rd_en     = 1'b1;
                rd_addr   = ring_next(head_r);
              end
            end
            ACT_SEARCH: begin
              if (count_r != '0) begin
                rd_en    = 1'b1;
                rd_addr  = head_r;
                scan_nxt = ring_next(head_r);
                left_nxt = count_r - 1'b1;
                key_nxt  = val;
              end
            end
            default: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          found_nxt = 1'b1;
        end else if (left_r != '0) begin
          rd_en    = 1'b1;
          rd_addr  = scan_r;
          scan_nxt = ring_next(scan_r);
          left_nxt = left_r - 1'b1;
        end
      end
      S_FRONT: front_nxt = rd_data;
      default: ;
    endcase

    res_load   = (state_nxt == S_IDLE) &&
                 ((state_r == S_IDLE && start) || state_r == S_EMIT);
    res.status = status;
    res.found  = found_nxt;
    res.front  = (count_nxt != '0) ? front_nxt : '0;
    res.rear   = (count_nxt != '0) ? rear_nxt : '0;
    res_count  = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    rear_r  <= rear_nxt;
    key_r   <= key_nxt;
    scan_r  <= scan_nxt;
    left_r  <= left_nxt;
    found_r <= found_nxt;
  end

endmodule

// ===== design/fifo_queue_with_search_core.sv =====
// Channel  Direction  Fields                                      Handshake
// in       input      action, data_value                          in_valid / in_stall
// out      output     status, found, front_value, rear_value,     out_valid / out_stall
//                     item_count, is_empty
//
// Enqueue, clear, a dequeue of an empty queue or of the last item, and a search of an empty
// queue finish on acceptance. A dequeue that leaves items passes S_FRONT and S_EMIT: the new
// front is read from the ring RAM. A search reads one stored entry per cycle through the
// single read port of the ring RAM, until a hit or the last entry, then passes S_EMIT.
// Reset clears head, tail and count; the RAM is not cleared, only valid entries are read.
// One item is in work at a time; a result waits in the output register under out_stall
// and the next item is taken once that register is free.
module fifo_queue_with_search_core
  import fqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_action,
  input  logic signed [DATA_W-1:0]                in_data_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              out_status,
  output logic                                    out_found,
  output logic signed [DATA_W-1:0]                out_front_value,
  output logic signed [DATA_W-1:0]                out_rear_value,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        out_item_count,
  output logic                                    out_is_empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic              busy;
  logic              out_free;
  logic              in_accept;
  logic              res_load;
  res_t              res;
  logic [CW-1:0]     res_count;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_found_r;
  logic [DATA_W-1:0] out_front_r;
  logic [DATA_W-1:0] out_rear_r;
  logic [CW-1:0]     out_count_r;

  // output register can take a result this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = busy || !out_free;
  assign in_accept = in_valid && !in_stall;

  fqs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fqs_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .act       (action_t'(in_action)),
    .val       (in_data_value),
    .out_free  (out_free),
    .busy      (busy),
    .res_load  (res_load),
    .res       (res),
    .res_count (res_count),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // result register: valid is control, fields are payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res.status;
      out_found_r  <= res.found;
      out_front_r  <= res.front;
      out_rear_r   <= res.rear;
      out_count_r  <= res_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_item_count  = out_count_r;
  assign out_is_empty    = (out_count_r == '0);

  // a new result never overwrites one that is still held
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded while output held");

  // no item is taken while a search or dequeue is still in work
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("item accepted while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_count <= CW'(QUEUE_DEPTH)))
    else $error("item count beyond depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_front_value == '0 && out_rear_value == '0))
    else $error("front or rear nonzero on empty queue");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_OK))
    else $error("found with error status");

endmodule

// ===== sim/fifo_queue_with_search_checker.sv =====
`timescale 1ns / 1ps

module fifo_queue_with_search_checker
  import fqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [1:0]               out_status,
  input  logic                     out_found,
  input  logic signed [DATA_W-1:0] out_front_value,
  input  logic signed [DATA_W-1:0] out_rear_value,
  input  logic [CNT_W-1:0]         out_item_count,
  input  logic                     out_is_empty,
  output int                       mismatch_count,
  output int                       pending_results
);

  // queue state as seen after one item
  typedef struct {
    status_t           status;
    logic              found;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] rear;
    logic [CNT_W-1:0]  count;
    logic              empty;
  } queue_view_t;

  logic [DATA_W-1:0] ring [QUEUE_DEPTH];
  int                head_pos;
  int                tail_pos;
  int                stored;
  int                errors;
  int                results_seen;
  queue_view_t       expected_views[$];

  function automatic queue_view_t apply_action(action_t act, logic [DATA_W-1:0] value);
    queue_view_t view;
    int          pos;
    view.status = ST_OK;
    view.found  = 1'b0;
    view.front  = '0;
    view.rear   = '0;
    case (act)
      ACT_ENQ: begin
        if (stored >= QUEUE_DEPTH) begin
          view.status = ST_ENQ_FULL;
        end else begin
          ring[tail_pos] = value;
          tail_pos = (tail_pos + 1) % QUEUE_DEPTH;
          stored++;
        end
      end
      ACT_DEQ: begin
        if (stored == 0) begin
          view.status = ST_DEQ_EMPTY;
        end else begin
          head_pos = (head_pos + 1) % QUEUE_DEPTH;
          stored--;
        end
      end
      ACT_SEARCH: begin
        pos = head_pos;
        for (int k = 0; k < stored; k++) begin
          if (ring[pos] == value) view.found = 1'b1;
          pos = (pos + 1) % QUEUE_DEPTH;
        end
      end
      default: begin
        // clear: entries keep their bits but are no longer valid
        head_pos = 0;
        tail_pos = 0;
        stored   = 0;
      end
    endcase
    if (stored != 0) begin
      view.front = ring[head_pos];
      view.rear  = ring[(tail_pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
    end
    view.count = CNT_W'(stored);
    view.empty = (stored == 0);
    return view;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: %s mismatch, expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    queue_view_t want;
    if (!rst_n) begin
      head_pos = 0;
      tail_pos = 0;
      stored   = 0;
      expected_views.delete();
    end else begin
      // push before pop: the queue stays in order either way
      if (in_valid && !in_stall)
        expected_views.push_back(apply_action(action_t'(in_action), in_data_value));
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: no item pending, status %0d count %0d",
                     results_seen, out_status, out_item_count);
        end else begin
          want = expected_views.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_status));
          check_field("found", DATA_W'(want.found), DATA_W'(out_found));
          check_field("front_value", want.front, out_front_value);
          check_field("rear_value", want.rear, out_rear_value);
          check_field("item_count", DATA_W'(want.count), DATA_W'(out_item_count));
          check_field("is_empty", DATA_W'(want.empty), DATA_W'(out_is_empty));
        end
        results_seen++;
      end
    end
    mismatch_count  <= errors;
    pending_results <= expected_views.size();
  end

endmodule

// ===== sim/fifo_queue_with_search_core_test.sv =====
`timescale 1ns / 1ps

module fifo_queue_with_search_core_test;
  import fqs_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_AT_ITEM = 500;     // random item that triggers the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;      // margin past the longest search
  localparam int CYCLE_LIMIT  = 400000;

  // bias of one sender burst: toward full, toward empty, or mixed
  typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

  // receiver stall patterns
  typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               in_action;
  logic signed [DATA_W-1:0] in_data_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               out_status;
  logic                     out_found;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_rear_value;
  logic [CNT_W-1:0]         out_item_count;
  logic                     out_is_empty;

  int   mismatch_count;
  int   pending_results;
  int   cycle_count = 0;
  logic hold_req;

  // recently offered enqueue values, so searches often hit stored items
  logic [DATA_W-1:0] recent_vals [QUEUE_DEPTH];
  int                recent_wr;

  fifo_queue_with_search_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_data_value  (in_data_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_front_value(out_front_value),
    .out_rear_value (out_rear_value),
    .out_item_count (out_item_count),
    .out_is_empty   (out_is_empty)
  );

  // checker sits beside the block and sees only the ports
  fifo_queue_with_search_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_data_value  (in_data_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_front_value(out_front_value),
    .out_rear_value (out_rear_value),
    .out_item_count (out_item_count),
    .out_is_empty   (out_is_empty),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the handshakes ever lock up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // value mix: extremes, a small range that makes duplicates, and full 32-bit noise
  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (roll < 35) return DATA_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic logic [DATA_W-1:0] pick_search_value();
    if ($urandom_range(0, 99) < 60) return recent_vals[$urandom_range(0, QUEUE_DEPTH - 1)];
    return pick_value();
  endfunction

  function automatic action_t pick_action(lean_t lean);
    int roll;
    int enq_pct;
    int deq_pct;
    roll = $urandom_range(0, 99);
    case (lean)
      LEAN_FILL: begin
        enq_pct = 65;
        deq_pct = 15;
      end
      LEAN_DRAIN: begin
        enq_pct = 20;
        deq_pct = 62;
      end
      default: begin
        enq_pct = 40;
        deq_pct = 35;
      end
    endcase
    if (roll < 2) return ACT_CLEAR;
    if (roll < 2 + enq_pct) return ACT_ENQ;
    if (roll < 2 + enq_pct + deq_pct) return ACT_DEQ;
    return ACT_SEARCH;
  endfunction

  // Offer one item and hold it until taken. Valid stays high into the next
  // item when gap is 0; otherwise it drops and waits out the gap before the task returns.
  task automatic push_item(action_t act, logic [DATA_W-1:0] value, int gap);
    in_action     <= act;
    in_data_value <= value;
    in_valid      <= 1'b1;
    if (act == ACT_ENQ) begin
      recent_vals[recent_wr] = value;
      recent_wr = (recent_wr + 1) % QUEUE_DEPTH;
    end
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    lean_t             lean;
    action_t           act;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] last_stored;
    int                burst_len;
    int                gap;
    int                sent;
    in_valid      <= 1'b0;
    in_action     <= ACT_ENQ;
    in_data_value <= '0;
    hold_req      <= 1'b0;
    rst_n         <= 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) recent_vals[i] = '0;
    recent_wr = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    push_item(ACT_DEQ, 32'h1234_5678, 0);     // dequeue on empty, data ignored
    push_item(ACT_SEARCH, 32'h0000_0000, 1);  // search of an empty queue
    push_item(ACT_ENQ, 32'h8000_0000, 0);     // most negative
    push_item(ACT_ENQ, 32'h7FFF_FFFF, 0);     // most positive
    push_item(ACT_ENQ, 32'h0000_0000, 2);
    push_item(ACT_ENQ, 32'hFFFF_FFFF, 0);
    push_item(ACT_SEARCH, 32'h7FFF_FFFF, 0);  // hit in the middle
    push_item(ACT_SEARCH, 32'h0000_0005, 0);  // miss over all entries
    push_item(ACT_DEQ, $urandom, 2);
    // fill up to exactly full
    for (int i = 0; i < 12; i++) push_item(ACT_ENQ, $urandom, $urandom_range(0, 1));
    last_stored = $urandom;
    push_item(ACT_ENQ, last_stored, 0);
    push_item(ACT_ENQ, 32'h5555_AAAA, 0);     // full: dropped, state kept
    push_item(ACT_SEARCH, last_stored, 0);    // hit on the newest entry
    push_item(ACT_CLEAR, $urandom, 1);
    push_item(ACT_DEQ, 32'h0000_0000, 0);     // empty again after clear
    push_item(ACT_SEARCH, 32'h8000_0000, 0);  // stale bits must not match

    // --- random part: bursts with a bias each, gaps between bursts ---
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      lean      = lean_t'($urandom_range(0, 2));
      burst_len = $urandom_range(4, 40);
      for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
        act   = pick_action(lean);
        value = (act == ACT_SEARCH) ? pick_search_value() : pick_value();
        gap   = 0;
        if (b == burst_len - 1 && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
        // long receiver hold-off while we keep offering
        if (sent == HOLD_AT_ITEM) hold_req <= 1'b1;
        push_item(act, value, gap);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // let the checker's count catch up with the last accepted item
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random-length segments with their own stall pattern, plus one
  // long hold-off so the block backs up into its input.
  initial begin : result_sink
    sink_mode_t mode;
    int         seg_len;
    bit         held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      mode    = sink_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(10, 150);
      if (hold_req && !held) begin
        held = 1'b1;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      repeat (seg_len) begin
        @(posedge clk);
        case (mode)
          SINK_OPEN:  out_stall <= 1'b0;
          SINK_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
          SINK_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
          default:    out_stall <= ((cycle_count % 7) < 3);
        endcase
      end
    end
  end

endmodule

// ===== filelist.f =====
design/fqs_pkg.sv
design/fqs_ram.sv
design/fqs_ctrl.sv
design/fifo_queue_with_search_core.sv
sim/fifo_queue_with_search_checker.sv
sim/fifo_queue_with_search_core_test.sv
